/* design/chained_hash_map_macros.svh */
// Assertion helpers for the hash map.
`ifndef CHAINED_HASH_MAP_MACROS_SVH
`define CHAINED_HASH_MAP_MACROS_SVH
`define CHM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define CHM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* design/chm_pkg.sv */
package chm_pkg;
	localparam int unsigned NUM_BUCKETS_DEF  = 1024;
	localparam int unsigned POOL_ENTRIES_DEF = 1024;
	localparam int unsigned KEY_W = 31;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned CNT_W = 11;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

/* design/chained_hash_map.sv */
// A clear returns its result first, once the output register is free, then sweeps
// the NUM_BUCKETS chain heads; the next transaction is taken once the sweep ends.
// Other commands compute the bucket remainder in the shared divider, read the head
// (S_HEAD, S_HEADW), compare chain entries one by one for a lookup or delete (S_RD, S_CMP),
// store an insert (S_INS) or unlink a delete (S_FREE, S_FRW), then load the output register.
// One transaction at a time; reset is asynchronous and followed by a NUM_BUCKETS sweep.
module chained_hash_map #(
	parameter int unsigned NUM_BUCKETS  = chm_pkg::NUM_BUCKETS_DEF,
	parameter int unsigned POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [chm_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// command[1:0], key[32:2], value[64:33], zero pad to 72 bits
	input  logic [71:0]             s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// found[0], value_out[32:1], status[34:33], zero pad to 40 bits
	output logic [39:0]             m_tdata
);
	import chm_pkg::*;
	`include "chained_hash_map_macros.svh"

	localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int unsigned PW = $clog2(POOL_ENTRIES + 1);
	localparam int unsigned PA = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int unsigned DW = CNT_W + 6;
	localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_HEAD  = 4'd3;
	localparam logic [3:0] S_HEADW = 4'd4;
	localparam logic [3:0] S_RD    = 4'd5;
	localparam logic [3:0] S_CMP   = 4'd6;
	localparam logic [3:0] S_INS   = 4'd7;
	localparam logic [3:0] S_FREE  = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;
	localparam logic [3:0] S_FRW   = 4'd10;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] bcount_q;
	logic [1:0]       cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [BW-1:0]    bkt_q;
	logic [PW-1:0]    cur_q, prev_q, slot_q;
	logic [PW-1:0]    free_q, never_q;
	logic [BW:0]      sweep_q;
	logic             found_q;
	logic [VAL_W-1:0] vout_q;
	logic [1:0]       status_q;
	logic             ovalid_q;
	logic [34:0]      rslt_q;
	logic             out_load;

	// Memories.
	logic [PW-1:0]    heads_mem [NUM_BUCKETS];
	logic [KEY_W-1:0] keys_mem  [POOL_ENTRIES];
	logic [VAL_W-1:0] vals_mem  [POOL_ENTRIES];
	logic [PW-1:0]    links_mem [POOL_ENTRIES];
	logic [PW-1:0]    head_rd_q;
	logic [KEY_W-1:0] key_rd_q;
	logic [VAL_W-1:0] val_rd_q;
	logic [PW-1:0]    link_rd_q;

	logic             hd_we, en_we, lk_we;
	logic [BW-1:0]    hd_addr;
	logic [PW-1:0]    hd_wdata;
	logic [PA-1:0]    en_addr, lk_addr, rd_addr;
	logic [PW-1:0]    lk_wdata;

	div_ctl_t         dctl;
	logic [DW-1:0]    rem;
	logic [DW-1:0]    divisor;
	logic             accept;

	always_comb begin
		if (bcount_q == '0)
			divisor = DW'(1);
		else if (32'(bcount_q) > NUM_BUCKETS)
			divisor = DW'(NUM_BUCKETS);
		else
			divisor = DW'(bcount_q);
	end

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	// The finished result moves to the output register once the previous one has left.
	assign out_load = (state_q == S_OUT) && (!ovalid_q || m_tready);

	chm_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && s_tdata[1:0] != CMD_CLEAR),
		.dividend (s_tdata[32:2]),
		.divisor  (divisor),
		.ctl      (dctl),
		.remainder(rem)
	);

	always_ff @(posedge clk) begin
		if (hd_we)
			heads_mem[hd_addr] <= hd_wdata;
		head_rd_q <= heads_mem[hd_addr];
	end

	always_ff @(posedge clk) begin
		if (en_we) begin
			keys_mem[en_addr] <= key_q;
			vals_mem[en_addr] <= val_q;
		end
		key_rd_q <= keys_mem[rd_addr];
		val_rd_q <= vals_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (lk_we)
			links_mem[lk_addr] <= lk_wdata;
		link_rd_q <= links_mem[rd_addr];
	end

	// Memory port control.
	always_comb begin
		hd_we    = 1'b0;
		hd_addr  = bkt_q;
		hd_wdata = NIL;
		en_we    = 1'b0;
		en_addr  = slot_q[PA-1:0];
		lk_we    = 1'b0;
		lk_addr  = slot_q[PA-1:0];
		lk_wdata = head_rd_q;
		rd_addr  = cur_q[PA-1:0];
		unique case (state_q)
			S_INIT: begin
				hd_we   = 1'b1;
				hd_addr = sweep_q[BW-1:0];
			end
			S_IDLE, S_DIV, S_HEAD: begin
				rd_addr = free_q[PA-1:0];
			end
			S_INS: begin
				hd_we    = 1'b1;
				hd_wdata = slot_q;
				en_we    = 1'b1;
				lk_we    = 1'b1;
			end
			S_FREE: begin
				// Unlink the match, then push it on the free list.
				hd_we    = (prev_q == NIL);
				hd_wdata = (link_rd_q < NIL) ? link_rd_q : NIL;
				lk_we    = (prev_q != NIL);
				lk_addr  = prev_q[PA-1:0];
				lk_wdata = (link_rd_q < NIL) ? link_rd_q : NIL;
			end
			S_FRW: begin
				lk_we    = 1'b1;
				lk_addr  = cur_q[PA-1:0];
				lk_wdata = free_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			rslt_q   <= '0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
			rslt_q   <= {status_q, vout_q, found_q};
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			sweep_q  <= '0;
			bcount_q <= CNT_W'(1024);
			free_q   <= NIL;
			never_q  <= '0;
		end else begin
			if (cfg_we)
				bcount_q <= cfg_wdata;
			unique case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == (BW+1)'(NUM_BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= s_tdata[1:0];
						key_q    <= s_tdata[32:2];
						val_q    <= s_tdata[64:33];
						found_q  <= 1'b0;
						vout_q   <= '0;
						status_q <= ST_DONE;
						if (s_tdata[1:0] == CMD_CLEAR) begin
							sweep_q  <= '0;
							free_q   <= NIL;
							never_q  <= '0;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (dctl.done) begin
						bkt_q   <= BW'(rem);
						state_q <= S_HEAD;
					end
				end
				S_HEAD: state_q <= S_HEADW;
				S_HEADW: begin
					prev_q <= NIL;
					cur_q  <= (head_rd_q < NIL) ? head_rd_q : NIL;
					if (cmd_q == CMD_INSERT) begin
						if (free_q < NIL) begin
							slot_q <= free_q;
							free_q <= (link_rd_q < NIL) ? link_rd_q : NIL;
							state_q <= S_INS;
						end else if (never_q < NIL) begin
							slot_q  <= never_q;
							never_q <= never_q + 1'b1;
							state_q <= S_INS;
						end else begin
							status_q <= ST_FULL;
							state_q  <= S_OUT;
						end
					end else if (head_rd_q < NIL) begin
						state_q <= S_RD;
					end else begin
						status_q <= ST_NOTFOUND;
						state_q  <= S_OUT;
					end
				end
				S_INS: state_q <= S_OUT;
				S_RD:  state_q <= S_CMP;
				S_CMP: begin
					if (key_rd_q == key_q) begin
						found_q <= 1'b1;
						if (cmd_q == CMD_LOOKUP) begin
							vout_q  <= val_rd_q;
							state_q <= S_OUT;
						end else begin
							state_q <= S_FREE;
						end
					end else if (link_rd_q < NIL) begin
						prev_q  <= cur_q;
						cur_q   <= link_rd_q;
						state_q <= S_RD;
					end else begin
						status_q <= ST_NOTFOUND;
						state_q  <= S_OUT;
					end
				end
				S_FREE: state_q <= S_FRW;
				S_FRW: begin
					free_q  <= cur_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					// A clear sweeps the heads after its result is out.
					if (out_load)
						state_q <= (cmd_q == CMD_CLEAR) ? S_INIT : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {5'd0, rslt_q};

	`CHM_ASSERT_IMP(a_ready_idle, s_tready, state_q == S_IDLE, "ready outside idle")
	`CHM_ASSERT_NXT(a_accept_busy, accept, !s_tready, "second transaction taken while busy")
	`CHM_ASSERT_IMP(a_div_only_busy, dctl.busy, state_q == S_DIV, "divider running out of turn")
	`CHM_ASSERT_IMP(a_free_range, 1'b1, free_q <= NIL && never_q <= NIL, "pool index out of range")
endmodule

/* design/chm_mod.sv */
// Restoring bit-serial remainder: one quotient bit per cycle.
module chm_mod (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [chm_pkg::KEY_W-1:0] dividend,
	input  logic [chm_pkg::CNT_W+5:0] divisor,
	output chm_pkg::div_ctl_t       ctl,
	output logic [chm_pkg::CNT_W+5:0] remainder
);
	import chm_pkg::*;
	localparam int unsigned DW = CNT_W + 6;
	localparam int unsigned BW = $clog2(KEY_W + 1);

	logic [KEY_W-1:0] num_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    div_q;
	logic [BW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;

	assign trial = {rem_q, num_q[KEY_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= BW'(KEY_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == BW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q})
				rem_q <= DW'(trial - {1'b0, div_q});
			else
				rem_q <= trial[DW-1:0];
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign remainder = rem_q;
endmodule
